>>> rtl/lfsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfsi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int MAX_ORDER   = 4;
  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 20;

  // datapath operations
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_MLO   = 4'd1;
  localparam logic [3:0] OP_MHI   = 4'd2;
  localparam logic [3:0] OP_U     = 4'd3;
  localparam logic [3:0] OP_START = 4'd4;
  localparam logic [3:0] OP_S     = 4'd5;
  localparam logic [3:0] OP_POW   = 4'd6;
  localparam logic [3:0] OP_MAC   = 4'd7;
  localparam logic [3:0] OP_WR    = 4'd8;
  localparam logic [3:0] OP_YR    = 4'd9;
  localparam logic [3:0] OP_YI    = 4'd10;
  localparam logic [3:0] OP_FIN   = 4'd11;

  // configuration register indexes
  localparam logic [1:0] REG_ORDER  = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_ORIGIN = 2'd2;
  localparam logic [1:0] REG_INV    = 2'd3;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic [2:0] k;
    logic [2:0] j;
  } cmd_t;

  typedef struct packed {
    logic [2:0] order;
    logic       bad;
    logic       fin_ok;
  } status_t;

  // lagrange weight matrices in Q4.16, per order, row j, power k
  localparam logic signed [COEF_W-1:0] COEF [4][5][5] = '{
    '{ '{ 20'sd65536, -20'sd65536, 20'sd0, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd65536, 20'sd0, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 } },
    '{ '{ 20'sd65536, -20'sd98304, 20'sd32768, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd131072, -20'sd65536, 20'sd0, 20'sd0 },
       '{ 20'sd0, -20'sd32768, 20'sd32768, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 } },
    '{ '{ 20'sd65536, -20'sd120149, 20'sd65536, -20'sd10923, 20'sd0 },
       '{ 20'sd0, 20'sd196608, -20'sd163840, 20'sd32768, 20'sd0 },
       '{ 20'sd0, -20'sd98304, 20'sd131072, -20'sd32768, 20'sd0 },
       '{ 20'sd0, 20'sd21845, -20'sd32768, 20'sd10923, 20'sd0 },
       '{ 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0 } },
    '{ '{ 20'sd65536, -20'sd136533, 20'sd95573, -20'sd27307, 20'sd2731 },
       '{ 20'sd0, 20'sd262144, -20'sd283989, 20'sd98304, -20'sd10923 },
       '{ 20'sd0, -20'sd196608, 20'sd311296, -20'sd131072, 20'sd16384 },
       '{ 20'sd0, 20'sd87381, -20'sd152917, 20'sd76459, -20'sd10923 },
       '{ 20'sd0, -20'sd16384, 20'sd30037, -20'sd16384, 20'sd2731 } }
  };

endpackage
`default_nettype wire

>>> rtl/lfsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lfsi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/lfsi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lfsi_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            action,
  input  wire lfsi_pkg::status_t status,
  output logic                 in_stall,
  output lfsi_pkg::cmd_t       cmd
);
  import lfsi_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MLO   = 4'd1;
  localparam logic [3:0] ST_MHI   = 4'd2;
  localparam logic [3:0] ST_U     = 4'd3;
  localparam logic [3:0] ST_START = 4'd4;
  localparam logic [3:0] ST_S     = 4'd5;
  localparam logic [3:0] ST_POW   = 4'd6;
  localparam logic [3:0] ST_MAC   = 4'd7;
  localparam logic [3:0] ST_WR    = 4'd8;
  localparam logic [3:0] ST_YR    = 4'd9;
  localparam logic [3:0] ST_YI    = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  logic [3:0] state, state_next;
  logic [2:0] k, k_next;
  logic [2:0] j, j_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // sequencing of one query
  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    cmd.k      = k;
    cmd.j      = j;
    case (state)
      ST_IDLE: begin
        if (accept && action) begin
          state_next = status.bad ? ST_FIN : ST_MLO;
        end
      end
      ST_MLO: begin
        cmd.op     = OP_MLO;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.op     = OP_MHI;
        state_next = ST_U;
      end
      ST_U: begin
        cmd.op     = OP_U;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.op     = OP_START;
        state_next = ST_S;
      end
      ST_S: begin
        cmd.op     = OP_S;
        k_next     = 3'd1;
        state_next = ST_POW;
      end
      ST_POW: begin
        cmd.op = OP_POW;
        if (k == status.order) begin
          k_next     = 3'd0;
          j_next     = 3'd0;
          state_next = ST_MAC;
        end else begin
          k_next = k + 3'd1;
        end
      end
      ST_MAC: begin
        cmd.op = OP_MAC;
        if (k == status.order) begin
          state_next = ST_WR;
        end else begin
          k_next = k + 3'd1;
        end
      end
      ST_WR: begin
        cmd.op     = OP_WR;
        state_next = ST_YR;
      end
      ST_YR: begin
        cmd.op     = OP_YR;
        state_next = ST_YI;
      end
      ST_YI: begin
        cmd.op = OP_YI;
        if (j == status.order) begin
          state_next = ST_FIN;
        end else begin
          j_next     = j + 3'd1;
          k_next     = 3'd0;
          state_next = ST_MAC;
        end
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        if (status.fin_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= 3'd0;
      j     <= 3'd0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

`ifndef SYNTHESIS
  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && action) |=> (state != ST_IDLE))
    else $error("query beat did not start work");
  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !action) |=> (state == ST_IDLE))
    else $error("sample write left idle");
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC || state == ST_POW) |-> (k <= status.order))
    else $error("power index beyond order");
  a_j_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YI) |-> (j <= status.order))
    else $error("window index beyond order");
`endif

endmodule
`default_nettype wire

>>> rtl/lfsi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lfsi_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lfsi_pkg::cmd_t        cmd,
  output lfsi_pkg::status_t          status,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  action,
  input  wire logic [9:0]            sample_index,
  input  wire logic signed [23:0]    sample_re,
  input  wire logic signed [23:0]    sample_im,
  input  wire logic signed [31:0]    position,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic signed [23:0]         result_re,
  output logic signed [23:0]         result_im,
  output logic                       error_code,
  output logic                       saturated
);
  import lfsi_pkg::*;

  // configuration
  logic [2:0]         order;
  logic [10:0]        sample_count;
  logic signed [31:0] origin;
  logic [31:0]        inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      order        <= 3'd2;
      sample_count <= 11'd1024;
      origin       <= 32'sd0;
      inv_step     <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORDER:  order        <= cfg_data[2:0];
        REG_COUNT:  sample_count <= cfg_data[10:0];
        REG_ORIGIN: origin       <= $signed(cfg_data);
        REG_INV:    inv_step     <= cfg_data;
        default:    ;
      endcase
    end
  end

  // effective count and order check
  logic [10:0] count;
  logic        bad;
  assign count = (sample_count > 11'(TABLE_DEPTH)) ? 11'(TABLE_DEPTH) : sample_count;
  assign bad   = (order < 3'd1) || (order > 3'(MAX_ORDER)) ||
                 ({9'd0, order} + 12'd1 > {1'b0, count});

  // sample table
  logic [ADDR_W-1:0]   start;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] ram_re_q, ram_im_q;
  logic                ram_we;
  assign ram_we = cmd.load && !action;
  assign raddr  = start + ADDR_W'(cmd.j);

  lfsi_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_re (
    .clk(clk), .we(ram_we), .waddr(sample_index), .wdata(sample_re),
    .raddr(raddr), .rdata(ram_re_q)
  );
  lfsi_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_DEPTH)) u_ram_im (
    .clk(clk), .we(ram_we), .waddr(sample_index), .wdata(sample_im),
    .raddr(raddr), .rdata(ram_im_q)
  );

  // working registers
  logic [32:0]        mag;
  logic               neg;
  logic [64:0]        prod;
  logic signed [50:0] u;
  logic signed [21:0] s;
  logic signed [33:0] pw [5];
  logic signed [33:0] pw_last;
  logic signed [55:0] wacc;
  logic signed [33:0] w;
  logic signed [61:0] acc_re, acc_im;

  // shared multiplier
  logic signed [33:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [58:0]       mul_p;
  logic signed [COEF_W-1:0] coef;
  logic [1:0]               ord_idx;

  assign ord_idx = 2'(order - 3'd1);
  assign coef    = COEF[ord_idx][cmd.j][cmd.k];

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 25'sd0;
    case (cmd.op)
      OP_MLO: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({9'd0, inv_step[15:0]});
      end
      OP_MHI: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({9'd0, inv_step[31:16]});
      end
      OP_POW: begin
        mul_a = pw_last;
        mul_b = 25'(s);
      end
      OP_MAC: begin
        mul_a = pw[cmd.k];
        mul_b = 25'(coef);
      end
      OP_YR: begin
        mul_a = w;
        mul_b = 25'($signed(ram_re_q));
      end
      OP_YI: begin
        mul_a = w;
        mul_b = 25'($signed(ram_im_q));
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // step arithmetic
  logic signed [32:0] diff;
  logic [64:0]        usum;
  logic [48:0]        ushift;
  logic signed [35:0] cand;
  logic [11:0]        hi;
  logic signed [51:0] sd;
  logic signed [58:0] p_rnd;
  logic signed [55:0] w_rnd;
  logic signed [61:0] re_rnd, im_rnd;
  logic signed [45:0] re_q, im_q;
  logic [23:0]        re_sat, im_sat;
  logic               re_clip, im_clip;

  assign diff   = 33'(position) - 33'(origin);
  assign usum   = prod + (neg ? 65'h0FFFF : 65'd0);
  assign ushift = usum[64:16];
  assign cand   = 36'(u[50:16]) - $signed({33'd0, order >> 1});
  assign hi     = {1'b0, count} - 12'd1 - {9'd0, order};
  assign sd     = 52'(u) - $signed({10'd0, start, 16'd0});
  assign p_rnd  = mul_p + 59'sd32768;
  assign w_rnd  = wacc + 56'sd32768;
  assign re_rnd = acc_re + 62'sd32768;
  assign im_rnd = acc_im + 62'sd32768;
  assign re_q   = re_rnd[61:16];
  assign im_q   = im_rnd[61:16];

  // output clipping
  always_comb begin
    re_clip = 1'b1;
    im_clip = 1'b1;
    if (re_q > 46'sd8388607) begin
      re_sat = 24'h7FFFFF;
    end else if (re_q < -46'sd8388608) begin
      re_sat = 24'h800000;
    end else begin
      re_sat  = re_q[23:0];
      re_clip = 1'b0;
    end
    if (im_q > 46'sd8388607) begin
      im_sat = 24'h7FFFFF;
    end else if (im_q < -46'sd8388608) begin
      im_sat = 24'h800000;
    end else begin
      im_sat  = im_q[23:0];
      im_clip = 1'b0;
    end
  end

  logic fin_ok, fin_go;
  assign fin_ok = !out_valid || !out_stall;
  assign fin_go = (cmd.op == OP_FIN) && fin_ok;

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= diff[32];
      mag <= diff[32] ? 33'(-diff) : 33'(diff);
    end
    case (cmd.op)
      OP_MLO: prod <= {16'd0, mul_p[48:0]};
      OP_MHI: prod <= prod + {mul_p[48:0], 16'd0};
      OP_U: u <= neg ? -$signed({2'b0, ushift}) : $signed({2'b0, ushift});
      OP_START: begin
        if (u < 0 || cand < 0) begin
          start <= '0;
        end else if (cand > $signed({24'd0, hi})) begin
          start <= hi[ADDR_W-1:0];
        end else begin
          start <= cand[ADDR_W-1:0];
        end
      end
      OP_S: begin
        if (sd > 52'sd1048576) begin
          s <= 22'sd1048576;
        end else if (sd < -52'sd1048576) begin
          s <= -22'sd1048576;
        end else begin
          s <= sd[21:0];
        end
        pw[0]   <= 34'sd65536;
        pw_last <= 34'sd65536;
      end
      OP_POW: begin
        pw[cmd.k] <= p_rnd[49:16];
        pw_last   <= p_rnd[49:16];
      end
      OP_MAC: wacc <= ((cmd.k == 3'd0) ? 56'sd0 : wacc) + mul_p[55:0];
      OP_WR:  w <= w_rnd[49:16];
      OP_YR:  acc_re <= ((cmd.j == 3'd0) ? 62'sd0 : acc_re) + 62'(mul_p);
      OP_YI:  acc_im <= ((cmd.j == 3'd0) ? 62'sd0 : acc_im) + 62'(mul_p);
      default: ;
    endcase
    if (fin_go) begin
      result_re  <= bad ? 24'sd0 : $signed(re_sat);
      result_im  <= bad ? 24'sd0 : $signed(im_sat);
      error_code <= bad;
      saturated  <= !bad && (re_clip || im_clip);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.order  = order;
  assign status.bad    = bad;
  assign status.fin_ok = fin_ok;

endmodule
`default_nettype wire

>>> rtl/lagrange_fixed_step_interpolator.sv
// channel  | handshake          | payload
// in       | in_valid/in_stall  | action, sample_index, sample_re, sample_im, position
// out      | out_valid/out_stall| result_re, result_im, error_code, saturated
// cfg      | cfg_we             | cfg_index, cfg_data
//
// a sample write gives no beat
// a query runs every product in turn through the single shared multiplier, holding in_stall
//   high until it is done; a query at a bad order goes straight to the result
// the result sits in an output register, so the next item is taken while it waits
// rst is synchronous; it restores the configuration defaults, table contents stay unknown
`timescale 1ns / 1ps
`default_nettype none
module lagrange_fixed_step_interpolator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic [9:0]         sample_index,
  input  wire logic signed [23:0] sample_re,
  input  wire logic signed [23:0] sample_im,
  input  wire logic signed [31:0] position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      result_re,
  output logic signed [23:0]      result_im,
  output logic                    error_code,
  output logic                    saturated
);
  import lfsi_pkg::*;

  cmd_t    cmd;
  status_t status;

  lfsi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .action(action),
    .status(status), .in_stall(in_stall), .cmd(cmd)
  );

  lfsi_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .sample_index(sample_index),
    .sample_re(sample_re), .sample_im(sample_im), .position(position),
    .out_stall(out_stall), .out_valid(out_valid),
    .result_re(result_re), .result_im(result_im),
    .error_code(error_code), .saturated(saturated)
  );

endmodule
`default_nettype wire

>>> tb/lagrange_fixed_step_interpolator_tb.sv
`timescale 1ns / 1ps
module lagrange_fixed_step_interpolator_tb;
  import lfsi_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic               err;
    logic               sat;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_ORDER;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [9:0] sample_index = '0;
  logic signed [23:0] sample_re = '0;
  logic signed [23:0] sample_im = '0;
  logic signed [31:0] position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] result_re;
  logic signed [23:0] result_im;
  logic error_code;
  logic saturated;

  lagrange_fixed_step_interpolator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of configuration and table
  logic [2:0]         p_order = 3'd2;
  logic [10:0]        p_count = 11'd1024;
  logic signed [31:0] p_origin = '0;
  logic [31:0]        p_inv = 32'd65536;
  longint             tab_re[TABLE_DEPTH];
  longint             tab_im[TABLE_DEPTH];
  bit                 tab_written[TABLE_DEPTH];

  interp_t pending_results[$];
  int      fail_count = 0;
  int      cycles = 0;
  int      hold_off = 0;
  bit      calm = 1'b0;

  function automatic longint coef(int n, int j, int k);
    longint m[4][5][5] = '{
      '{ '{65536, -65536, 0, 0, 0}, '{0, 65536, 0, 0, 0}, '{0, 0, 0, 0, 0},
         '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0} },
      '{ '{65536, -98304, 32768, 0, 0}, '{0, 131072, -65536, 0, 0},
         '{0, -32768, 32768, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0} },
      '{ '{65536, -120149, 65536, -10923, 0}, '{0, 196608, -163840, 32768, 0},
         '{0, -98304, 131072, -32768, 0}, '{0, 21845, -32768, 10923, 0},
         '{0, 0, 0, 0, 0} },
      '{ '{65536, -136533, 95573, -27307, 2731}, '{0, 262144, -283989, 98304, -10923},
         '{0, -196608, 311296, -131072, 16384}, '{0, 87381, -152917, 76459, -10923},
         '{0, -16384, 30037, -16384, 2731} } };
    return m[n-1][j][k];
  endfunction

  function automatic longint round16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic int eff_count();
    return (p_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(p_count);
  endfunction

  function automatic bit order_bad();
    return p_order < 1 || p_order > MAX_ORDER || int'(p_order) > eff_count() - 1;
  endfunction

  // window start and sample offset in Q.16 sample units
  function automatic void locate(input logic signed [31:0] pos, output longint st,
                                 output longint s);
    longint diff, u;
    logic [63:0] mag, prod;
    int n;
    n = p_order;
    diff = longint'(pos) - longint'(p_origin);
    mag = diff < 0 ? 64'(-diff) : 64'(diff);
    prod = mag * 64'(p_inv);
    if (diff < 0) u = -longint'((prod + 64'hFFFF) >> 16);
    else u = longint'(prod >> 16);
    if (u < 0) st = 0;
    else begin
      st = (u >>> 16) - n / 2;
      if (st < 0) st = 0;
    end
    if (st + n > eff_count() - 1) st = eff_count() - 1 - n;
    s = u - st * 65536;
    if (s > 16 * 65536) s = 16 * 65536;
    if (s < -16 * 65536) s = -16 * 65536;
  endfunction

  function automatic interp_t interpolate(logic signed [31:0] pos);
    interp_t r;
    longint st, s, w, acc_re, acc_im, v;
    longint pw[5];
    int n;
    r = '{re: '0, im: '0, err: 1'b0, sat: 1'b0};
    if (order_bad()) begin
      r.err = 1'b1;
      return r;
    end
    n = p_order;
    locate(pos, st, s);
    pw[0] = 65536;
    for (int k = 1; k <= n; k++) pw[k] = round16(pw[k-1] * s);
    acc_re = 0;
    acc_im = 0;
    for (int j = 0; j <= n; j++) begin
      w = 0;
      for (int k = 0; k <= n; k++) w += coef(n, j, k) * pw[k];
      w = round16(w);
      acc_re += w * tab_re[st + j];
      acc_im += w * tab_im[st + j];
    end
    v = round16(acc_re);
    if (v > 8388607) begin v = 8388607; r.sat = 1'b1; end
    if (v < -8388608) begin v = -8388608; r.sat = 1'b1; end
    r.re = 24'(v);
    v = round16(acc_im);
    if (v > 8388607) begin v = 8388607; r.sat = 1'b1; end
    if (v < -8388608) begin v = -8388608; r.sat = 1'b1; end
    r.im = 24'(v);
    return r;
  endfunction

  function automatic int idle_len();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // offer one beat and wait until it is taken
  task automatic offer(bit act, logic [9:0] idx, logic signed [23:0] re,
                       logic signed [23:0] im, logic signed [31:0] pos);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    sample_index <= idx;
    sample_re <= re;
    sample_im <= im;
    position <= pos;
    do @(posedge clk); while (in_stall);
    if (!act) begin
      tab_re[idx] = re;
      tab_im[idx] = im;
      tab_written[idx] = 1'b1;
    end else begin
      pending_results.push_back(interpolate(pos));
    end
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic load_sample(logic [9:0] idx);
    offer(1'b0, idx, rand_sample(), rand_sample(), '0);
  endtask

  // query, loading any unwritten entry of its window first
  task automatic query(logic signed [31:0] pos);
    longint st, s;
    if (!order_bad()) begin
      locate(pos, st, s);
      for (longint i = st; i <= st + p_order; i++)
        if (!tab_written[i]) load_sample(10'(i));
    end
    offer(1'b1, '0, 24'($urandom), 24'($urandom), pos);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [2:0] o, logic [10:0] c, logic signed [31:0] org,
                           logic [31:0] inv);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_ORDER;  cfg_data <= 32'(o);   @(posedge clk);
    cfg_index <= REG_COUNT;  cfg_data <= 32'(c);   @(posedge clk);
    cfg_index <= REG_ORIGIN; cfg_data <= org;      @(posedge clk);
    cfg_index <= REG_INV;    cfg_data <= inv;      @(posedge clk);
    cfg_we <= 1'b0;
    p_order = o;
    p_count = c;
    p_origin = org;
    p_inv = inv;
  endtask

  // position that lands near sample t under the current mapping
  function automatic logic signed [31:0] near_sample(longint t);
    longint frac;
    frac = t * 65536 + $urandom_range(0, 65535);
    if (p_inv == 0) return 32'($urandom);
    return 32'(longint'(p_origin) + (frac * 65536) / longint'(p_inv));
  endfunction

  task automatic random_items(int total);
    int c;
    for (int i = 0; i < total; i++) begin
      c = eff_count();
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 3) == 0) load_sample(10'($urandom));
        else load_sample(10'($urandom_range(0, c - 1)));
      end else if ($urandom_range(0, 4) == 0) begin
        query(32'($urandom));
      end else begin
        query(near_sample(longint'($urandom_range(0, c + 3)) - 2));
      end
    end
  endtask

  // directed checks at reset configuration and field extremes
  task automatic test_basic();
    for (int i = 0; i < 4; i++) load_sample(10'(i));
    load_sample(10'd1023);
    offer(1'b0, 10'd1022, 24'sh7FFFFF, 24'sh800000, '0);
    offer(1'b0, 10'd1021, 24'sh800000, 24'sh7FFFFF, '0);
    query(32'sh0000_0000);
    query(32'sh0001_8000);
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    query(32'sh03FF_0000);
    query(32'sh03FE_C000);
  endtask

  // orders out of range, order above count minus one, and order one at the smallest count
  task automatic test_bad_order();
    configure(3'd0, 11'd1024, 32'sd0, 32'd65536);
    query(32'sh0001_0000);
    configure(3'd5, 11'd1024, 32'sd0, 32'd65536);
    query(32'sh0001_0000);
    configure(3'd7, 11'd1024, 32'sd0, 32'd65536);
    query(32'sh0002_0000);
    configure(3'd4, 11'd4, 32'sd0, 32'd65536);
    query(32'sh0001_0000);
    configure(3'd1, 11'd2, 32'sd0, 32'd65536);
    query(32'sh0000_8000);
    query(32'shFFF0_0000);
  endtask

  // zero inverse step, count above depth, extreme origin and step
  task automatic test_mapping();
    configure(3'd3, 11'd2047, 32'sh8000_0000, 32'd0);
    query(32'sh7FFF_FFFF);
    query(32'sh1234_5678);
    configure(3'd4, 11'd2047, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    configure(3'd2, 11'd1024, 32'sh8000_0000, 32'd1);
    query(32'sh7FFF_FFFF);
    query(32'sh8000_0000);
  endtask

  // receiver holds off while queries keep coming
  task automatic test_backpressure();
    configure(3'd4, 11'd64, 32'sd0, 32'd65536);
    hold_off = 600;
    for (int i = 0; i < 12; i++) query(near_sample($urandom_range(0, 63)));
  endtask

  task automatic test_random();
    configure(3'd2, 11'd48, -32'sd1000000, 32'd98304);
    random_items(60);
    configure(3'd1, 11'd2, 32'sd65536, 32'd65536);
    random_items(30);
    configure(3'd4, 11'd1024, 32'sd0, 32'd4096);
    calm = 1'b1;
    random_items(20);
    calm = 1'b0;
    configure(3'd3, 11'd40, 32'sh0100_0000, 32'd200000);
    random_items(60);
    configure(3'd4, 11'd5, 32'sd0, 32'd65536);
    random_items(40);
    configure(3'($urandom_range(1, 4)), 11'($urandom_range(2, 100)),
              32'($urandom), 32'($urandom_range(1000, 300000)));
    random_items(70);
  endtask

  // receiver stall, with a counted hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 2) ||
                   (out_stall && $urandom_range(0, 19) < 17);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    interp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat re=%0d im=%0d", result_re, result_im);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_re !== e.re) begin
          $error("result_re expected %0d got %0d", e.re, result_re);
          fail_count++;
        end
        if (result_im !== e.im) begin
          $error("result_im expected %0d got %0d", e.im, result_im);
          fail_count++;
        end
        if (error_code !== e.err) begin
          $error("error_code expected %0d got %0d", e.err, error_code);
          fail_count++;
        end
        if (saturated !== e.sat) begin
          $error("saturated expected %0d got %0d", e.sat, saturated);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lagrange_fixed_step_interpolator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic();
    test_bad_order();
    test_mapping();
    test_backpressure();
    test_random();
    drain();
    if (fail_count == 0 && pending_results.size() == 0)
      $display("lagrange_fixed_step_interpolator_tb OK");
    else
      $display("lagrange_fixed_step_interpolator_tb NOT OK");
    $finish;
  end

endmodule
